/* rtl/core/cfd_pkg.sv */
// Shared types and constants for the dielectric Coulomb pair force core.
// No dependencies; cfd_front, cfd_back and the top level import this package.
`default_nettype none

package cfd_pkg;

	// Default module parameters
	localparam int FRAC_BITS_DEF = 16;
	localparam int ACC_WIDTH_DEF = 48;

	// Fixed widths of the ports
	localparam int OUT_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int FACTOR_W   = 17;

	// round(2^32 / (4 * sqrt(pi)))
	localparam logic [63:0] INV_4_ROOT_PI_Q32 = 64'd605793953;

	// Item kinds on the input port
	localparam logic [1:0] KIND_HDR  = 2'd0;
	localparam logic [1:0] KIND_SELF = 2'd1;
	localparam logic [1:0] KIND_NBR  = 2'd2;

	// Operations after classification
	localparam logic [1:0] OP_HDR  = 2'd0;
	localparam logic [1:0] OP_SELF = 2'd1;
	localparam logic [1:0] OP_NBR  = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_COULOMB = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_FACTOR3 = 3'd4;

	// One classified word in the queue between front and back
	typedef struct packed {
		logic [1:0]  op;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
		logic [31:0] charge;
		logic [31:0] permittivity;
		logic [1:0]  special_class;
		logic [31:0] curvature;
		logic [31:0] area;
		logic [31:0] pair_cutoff_sq;
		logic [31:0] pair_scale;
		logic        last;
	} item_t;

endpackage

`default_nettype wire

/* rtl/core/cfd_front.sv */
// Input side of the core: accepts words, classifies the kind and holds
// them in a two-entry queue for the back end. Depends on cfd_pkg.
`default_nettype none

module cfd_front import cfd_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic [31:0] vec_x,
	input  wire logic [31:0] vec_y,
	input  wire logic [31:0] vec_z,
	input  wire logic [31:0] charge,
	input  wire logic [31:0] permittivity,
	input  wire logic [1:0]  special_class,
	input  wire logic [31:0] curvature,
	input  wire logic [31:0] area,
	input  wire logic [31:0] pair_cutoff_sq,
	input  wire logic [31:0] pair_scale,
	input  wire logic        last,
	input  wire logic        pop,
	output logic             head_valid,
	output item_t            head
);

	item_t       ent_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	item_t       cls;
	logic        push;

	// Classify the incoming word
	always_comb begin
		cls.vec_x          = vec_x;
		cls.vec_y          = vec_y;
		cls.vec_z          = vec_z;
		cls.charge         = charge;
		cls.permittivity   = permittivity;
		cls.special_class  = special_class;
		cls.curvature      = curvature;
		cls.area           = area;
		cls.pair_cutoff_sq = pair_cutoff_sq;
		cls.pair_scale     = pair_scale;
		cls.last           = last;
		case (kind)
			KIND_HDR:  cls.op = OP_HDR;
			KIND_SELF: cls.op = OP_SELF;
			KIND_NBR:  cls.op = OP_NBR;
			default:   cls.op = OP_NONE;
		endcase
	end

	assign in_ready   = (cnt_q != 2'd2);
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = ent_q[rd_ptr_q];

	// Store pushed words
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= cls;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> cnt_q != 2'd0)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

/* rtl/core/cfd_mul.sv */
// 64 x 64 multiplier built from four 32 x 32 partial products, one per cycle.
// No dependencies.
`default_nettype none

module cfd_mul (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [63:0]  a,
	input  wire logic [63:0]  b,
	output logic              done,
	output logic [127:0]      prod
);

	logic [63:0]  a_q;
	logic [63:0]  b_q;
	logic [2:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [63:0]  pp_s1;
	logic [1:0]   sh_s1;
	logic [127:0] prod_q;
	logic [31:0]  pa;
	logic [31:0]  pb;
	logic [1:0]   sh;

	// Select the partial product for this step
	always_comb begin
		case (cnt_q[1:0])
			2'd0: begin pa = a_q[31:0];  pb = b_q[31:0];  sh = 2'd0; end
			2'd1: begin pa = a_q[31:0];  pb = b_q[63:32]; sh = 2'd1; end
			2'd2: begin pa = a_q[63:32]; pb = b_q[31:0];  sh = 2'd1; end
			default: begin pa = a_q[63:32]; pb = b_q[63:32]; sh = 2'd2; end
		endcase
	end

	// Payload: multiply, then accumulate the registered product in the next cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (busy_q) begin
			if (cnt_q != 3'd4) begin
				pp_s1 <= 64'(pa) * 64'(pb);
				sh_s1 <= sh;
			end
			if (cnt_q != 3'd0) begin
				prod_q <= prod_q + (128'(pp_s1) << {sh_s1, 5'd0});
			end
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 3'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = prod_q;

endmodule

`default_nettype wire

/* rtl/core/cfd_div.sv */
// Rounded 128 / 64 bit restoring divider, one quotient bit per cycle.
// No dependencies; a zero divisor gives an all-ones quotient.
`default_nettype none

module cfd_div (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] n,
	input  wire logic [63:0]  d,
	output logic              done,
	output logic [127:0]      quo
);

	logic [127:0] n_q;
	logic [63:0]  d_q;
	logic [63:0]  rem_q;
	logic [127:0] q_q;
	logic         dz_q;
	logic [6:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [64:0]  r65;
	logic         ge;

	assign r65 = {rem_q, n_q[127]};
	assign ge  = (r65 >= {1'b0, d_q});

	// Shift one numerator bit in, subtract when it fits
	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n + 128'(d >> 1);
			d_q   <= d;
			dz_q  <= (d == 64'd0);
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[126:0], 1'b0};
			rem_q <= ge ? 64'(r65 - {1'b0, d_q}) : r65[63:0];
			q_q   <= {q_q[126:0], ge};
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd127;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo  = dz_q ? '1 : q_q;

endmodule

`default_nettype wire

/* rtl/core/cfd_sqrt.sv */
// Floor square root of a 128-bit value, two radicand bits per cycle.
// No dependencies.
`default_nettype none

module cfd_sqrt (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	input  wire logic [127:0] x,
	output logic              done,
	output logic [63:0]       root
);

	logic [127:0] x_q;
	logic [66:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q;
	logic         done_q;
	logic [66:0]  rem2;
	logic [66:0]  trial;
	logic         ge;

	assign rem2  = {rem_q[64:0], x_q[127:126]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = (rem2 >= trial);

	// One result bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[125:0], 2'b00};
			rem_q  <= ge ? (rem2 - trial) : rem2;
			root_q <= {root_q[62:0], ge};
		end
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 6'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd63;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

/* rtl/core/cfd_back.sv */
// Back end: sequencer over a shared multiplier, divider and square root
// that works one queued word at a time, with accumulators and result register.
// Depends on cfd_pkg, cfd_mul, cfd_div and cfd_sqrt.
`default_nettype none

module cfd_back import cfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire item_t                 head,
	output logic                       pop,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_W-1:0]           force_x,
	output logic [OUT_W-1:0]           force_y,
	output logic [OUT_W-1:0]           force_z,
	output logic [OUT_W-1:0]           field_x,
	output logic [OUT_W-1:0]           field_y,
	output logic [OUT_W-1:0]           field_z,
	output logic                       saturated
);

	localparam logic [63:0] D2_FLOOR =
		((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;
	localparam logic signed [65:0] ACC_HI = (66'sd1 <<< (ACC_WIDTH - 1)) - 66'sd1;
	localparam logic signed [65:0] ACC_LO = -ACC_HI - 66'sd1;

	// Sequencer states
	localparam logic [4:0] ST_IDLE   = 5'd0;
	localparam logic [4:0] ST_DISP   = 5'd1;
	localparam logic [4:0] ST_WAIT   = 5'd2;
	localparam logic [4:0] ST_FIN    = 5'd3;
	localparam logic [4:0] ST_SF_RT  = 5'd4;
	localparam logic [4:0] ST_SF_M1  = 5'd5;
	localparam logic [4:0] ST_SF_M2  = 5'd6;
	localparam logic [4:0] ST_SF_M3  = 5'd7;
	localparam logic [4:0] ST_SF_ACC = 5'd8;
	localparam logic [4:0] ST_NB_D2  = 5'd9;
	localparam logic [4:0] ST_NB_CHK = 5'd10;
	localparam logic [4:0] ST_NB_R   = 5'd11;
	localparam logic [4:0] ST_NB_E1  = 5'd12;
	localparam logic [4:0] ST_NB_E2  = 5'd13;
	localparam logic [4:0] ST_NB_E3  = 5'd14;
	localparam logic [4:0] ST_NB_E4  = 5'd15;
	localparam logic [4:0] ST_NB_E5  = 5'd16;
	localparam logic [4:0] ST_NB_C   = 5'd17;
	localparam logic [4:0] ST_NB_FM  = 5'd18;
	localparam logic [4:0] ST_NB_FA  = 5'd19;
	localparam logic [4:0] ST_NB_GM  = 5'd20;
	localparam logic [4:0] ST_NB_GA  = 5'd21;

	// Rounded right shift of a product, saturated to 64 bits; top bit flags clip
	function automatic logic [64:0] rnd_sat(input logic [127:0] p, input int sh);
		logic [127:0] w;
		w = (p + (128'd1 << (sh - 1))) >> sh;
		return (w[127:64] != 64'd0) ? {1'b1, 64'hFFFF_FFFF_FFFF_FFFF} : {1'b0, w[63:0]};
	endfunction

	function automatic logic [64:0] sat64(input logic [127:0] q);
		return (q[127:64] != 64'd0) ? {1'b1, 64'hFFFF_FFFF_FFFF_FFFF} : {1'b0, q[63:0]};
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// Saturating signed accumulate; top bit flags clip
	function automatic logic [ACC_WIDTH:0] acc_add(input logic [ACC_WIDTH-1:0] acc,
			input logic neg, input logic [63:0] mag);
		logic signed [65:0] a;
		logic signed [65:0] m;
		logic signed [65:0] s;
		a = 66'($signed(acc));
		m = $signed({2'b00, mag});
		s = neg ? (a - m) : (a + m);
		if (s > ACC_HI) begin
			return {1'b1, ACC_HI[ACC_WIDTH-1:0]};
		end else if (s < ACC_LO) begin
			return {1'b1, ACC_LO[ACC_WIDTH-1:0]};
		end
		return {1'b0, s[ACC_WIDTH-1:0]};
	endfunction

	// Configuration registers
	logic [31:0]          coul_q;
	logic [FACTOR_W-1:0]  fac_q [4];

	// Center atom and sums
	logic [31:0]          cpos_q [3];
	logic [31:0]          cchg_q;
	logic [31:0]          cperm_q;
	logic [ACC_WIDTH-1:0] force_q [3];
	logic [ACC_WIDTH-1:0] field_q [3];
	logic                 clip_q;

	// Sequencer
	logic [4:0]           st_q;
	logic [4:0]           ret_q;
	item_t                it_q;
	logic [1:0]           k_q;
	logic [32:0]          u_q [3];
	logic                 dn_q [3];
	logic [127:0]         dist2_q;
	logic [63:0]          r_q;
	logic [63:0]          sf_q;
	logic [63:0]          e_q;
	logic [63:0]          ef_q;
	logic [63:0]          c_q;

	// Result register
	logic                 out_valid_q;
	logic [OUT_W-1:0]     out_q [6];
	logic                 sat_q;

	// Shared units
	logic         mul_start;
	logic [63:0]  mul_a;
	logic [63:0]  mul_b;
	logic         mul_done;
	logic [127:0] mul_p;
	logic         div_start;
	logic [127:0] div_n;
	logic [63:0]  div_d;
	logic         div_done;
	logic [127:0] div_q;
	logic         sqrt_start;
	logic [127:0] sqrt_x;
	logic         sqrt_done;
	logic [63:0]  sqrt_root;

	cfd_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_p)
	);

	cfd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .n(div_n), .d(div_d),
		.done(div_done), .quo(div_q)
	);

	cfd_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .x(sqrt_x),
		.done(sqrt_done), .root(sqrt_root)
	);

	// Word views and shared arithmetic
	logic [31:0]          pos [3];
	logic [32:0]          dvec [3];
	logic [32:0]          udist [3];
	logic [64:0]          rs_f;
	logic [64:0]          rs_32;
	logic [64:0]          qs;
	logic [FACTOR_W-1:0]  factor;
	logic                 curv_lt;
	logic                 dist_ok;
	logic [1:0]           k_nx;
	logic                 negj;
	logic                 negi;
	logic [ACC_WIDTH:0]   acc_fd;
	logic [ACC_WIDTH:0]   acc_fc;
	logic [ACC_WIDTH:0]   acc_sf;
	logic                 out_free;
	logic                 any_done;
	logic                 emit;

	assign pos[0] = it_q.vec_x;
	assign pos[1] = it_q.vec_y;
	assign pos[2] = it_q.vec_z;

	for (genvar g = 0; g < 3; g++) begin : g_dist
		assign dvec[g]  = 33'($signed(cpos_q[g])) - 33'($signed(pos[g]));
		assign udist[g] = dvec[g][32] ? (~dvec[g] + 33'd1) : dvec[g];
	end

	assign rs_f    = rnd_sat(mul_p, FRAC_BITS);
	assign rs_32   = rnd_sat(mul_p, 32);
	assign qs      = sat64(div_q);
	assign factor  = fac_q[it_q.special_class];
	assign curv_lt = it_q.curvature[31] || (64'(it_q.curvature) < sqrt_root);
	assign dist_ok = (dist2_q > 128'(D2_FLOOR))
		&& (dist2_q < (128'(it_q.pair_cutoff_sq) << FRAC_BITS));
	assign k_nx    = k_q + 2'd1;
	assign negj    = it_q.charge[31];
	assign negi    = cchg_q[31];
	assign acc_sf  = acc_add(field_q[k_q], (it_q.curvature[31] != it_q.charge[31])
		!= pos[k_q][31], rs_f[63:0]);
	assign acc_fd  = acc_add(field_q[k_q], negj != dn_q[k_q], qs[63:0]);
	assign acc_fc  = acc_add(force_q[k_q], (negj != negi) != dn_q[k_q], qs[63:0]);
	assign out_free = !out_valid_q || out_ready;
	assign any_done = mul_done || div_done || sqrt_done;
	assign pop      = (st_q == ST_IDLE) && head_valid;
	assign emit     = (st_q == ST_FIN) && it_q.last && out_free;

	// Start the shared units
	always_comb begin
		mul_start  = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		div_n      = '0;
		div_d      = '0;
		sqrt_start = 1'b0;
		sqrt_x     = '0;
		case (st_q)
			ST_DISP: begin
				if (it_q.op == OP_SELF) begin
					sqrt_start = 1'b1;
					sqrt_x     = 128'(it_q.area) << FRAC_BITS;
				end else if (it_q.op == OP_NBR) begin
					mul_start = 1'b1;
					mul_a     = 64'(udist[0]);
					mul_b     = 64'(udist[0]);
				end
			end
			ST_SF_RT: begin
				mul_start = curv_lt;
				mul_a     = 64'(mag32(it_q.curvature));
				mul_b     = sqrt_root;
			end
			ST_SF_M1: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = 64'(mag32(it_q.charge));
			end
			ST_SF_M2: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = INV_4_ROOT_PI_Q32;
			end
			ST_SF_M3: begin
				mul_start = 1'b1;
				mul_a     = rs_32[63:0];
				mul_b     = 64'(mag32(pos[0]));
			end
			ST_SF_ACC: begin
				mul_start = (k_q != 2'd2);
				mul_a     = sf_q;
				mul_b     = 64'(mag32(pos[k_nx]));
			end
			ST_NB_D2: begin
				mul_start = (k_q != 2'd2);
				mul_a     = 64'(u_q[k_nx]);
				mul_b     = 64'(u_q[k_nx]);
			end
			ST_NB_CHK: begin
				sqrt_start = dist_ok;
				sqrt_x     = dist2_q << (2 * FRAC_BITS);
			end
			ST_NB_R: begin
				mul_start = 1'b1;
				mul_a     = 64'(coul_q);
				mul_b     = 64'(it_q.pair_scale);
			end
			ST_NB_E1: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = 64'(mag32(it_q.charge));
			end
			ST_NB_E2: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = 64'(factor);
			end
			ST_NB_E3: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = 64'(cperm_q);
			end
			ST_NB_E4: begin
				mul_start = 1'b1;
				mul_a     = rs_f[63:0];
				mul_b     = 64'(mag32(cchg_q));
			end
			ST_NB_E5: begin
				div_start = 1'b1;
				div_n     = 128'(u_q[0]) << (3 * FRAC_BITS);
				div_d     = r_q;
			end
			ST_NB_C: begin
				mul_start = 1'b1;
				mul_a     = e_q;
				mul_b     = qs[63:0];
			end
			ST_NB_FM, ST_NB_GM: begin
				div_start = 1'b1;
				div_n     = mul_p;
				div_d     = dist2_q[63:0];
			end
			ST_NB_FA: begin
				mul_start = 1'b1;
				mul_a     = ef_q;
				mul_b     = c_q;
			end
			ST_NB_GA: begin
				div_start = (k_q != 2'd2);
				div_n     = 128'(u_q[k_nx]) << (3 * FRAC_BITS);
				div_d     = r_q;
			end
			default: begin
			end
		endcase
	end

	// Hold the popped word and intermediate values
	always_ff @(posedge clk) begin
		if (pop) begin
			it_q <= head;
		end
		case (st_q)
			ST_DISP: begin
				for (int i = 0; i < 3; i++) begin
					u_q[i]  <= udist[i];
					dn_q[i] <= dvec[i][32];
				end
			end
			ST_SF_M3: sf_q <= rs_32[63:0];
			ST_NB_R:  r_q  <= sqrt_root;
			ST_NB_E4: e_q  <= rs_f[63:0];
			ST_NB_E5: ef_q <= rs_f[63:0];
			ST_NB_C:  c_q  <= qs[63:0];
			default: begin
			end
		endcase
	end

	// Sequencer, configuration, accumulators and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			ret_q       <= ST_IDLE;
			k_q         <= 2'd0;
			dist2_q     <= '0;
			coul_q      <= 32'd65536;
			fac_q[0]    <= 17'd65536;
			fac_q[1]    <= '0;
			fac_q[2]    <= '0;
			fac_q[3]    <= '0;
			cchg_q      <= '0;
			cperm_q     <= '0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
			sat_q       <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cpos_q[i]  <= '0;
				force_q[i] <= '0;
				field_q[i] <= '0;
			end
			for (int i = 0; i < 6; i++) begin
				out_q[i] <= '0;
			end
		end else begin
			// Write configuration
			if (cfg_we) begin
				case (cfg_index)
					CFG_COULOMB: coul_q   <= cfg_data;
					CFG_FACTOR0: fac_q[0] <= cfg_data[FACTOR_W-1:0];
					CFG_FACTOR1: fac_q[1] <= cfg_data[FACTOR_W-1:0];
					CFG_FACTOR2: fac_q[2] <= cfg_data[FACTOR_W-1:0];
					CFG_FACTOR3: fac_q[3] <= cfg_data[FACTOR_W-1:0];
					default: begin
					end
				endcase
			end

			// Raise the result on emit, drop it once taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				ST_IDLE: begin
					if (head_valid) begin
						st_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					case (it_q.op)
						OP_HDR: begin
							for (int i = 0; i < 3; i++) begin
								force_q[i] <= '0;
								field_q[i] <= '0;
							end
							clip_q    <= 1'b0;
							cpos_q[0] <= it_q.vec_x;
							cpos_q[1] <= it_q.vec_y;
							cpos_q[2] <= it_q.vec_z;
							cchg_q    <= it_q.charge;
							cperm_q   <= it_q.permittivity;
							st_q      <= ST_FIN;
						end
						OP_SELF: begin
							ret_q <= ST_SF_RT;
							st_q  <= ST_WAIT;
						end
						OP_NBR: begin
							k_q     <= 2'd0;
							dist2_q <= '0;
							ret_q   <= ST_NB_D2;
							st_q    <= ST_WAIT;
						end
						default: st_q <= ST_FIN;
					endcase
				end
				ST_WAIT: begin
					if (any_done) begin
						st_q <= ret_q;
					end
				end
				ST_SF_RT: begin
					for (int i = 0; i < 3; i++) begin
						field_q[i] <= '0;
					end
					if (curv_lt) begin
						ret_q <= ST_SF_M1;
						st_q  <= ST_WAIT;
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_SF_M1: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_SF_M2;
					st_q   <= ST_WAIT;
				end
				ST_SF_M2: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_SF_M3;
					st_q   <= ST_WAIT;
				end
				ST_SF_M3: begin
					clip_q <= clip_q | rs_32[64];
					k_q    <= 2'd0;
					ret_q  <= ST_SF_ACC;
					st_q   <= ST_WAIT;
				end
				ST_SF_ACC: begin
					field_q[k_q] <= acc_sf[ACC_WIDTH-1:0];
					clip_q       <= clip_q | rs_f[64] | acc_sf[ACC_WIDTH];
					if (k_q == 2'd2) begin
						st_q <= ST_FIN;
					end else begin
						k_q  <= k_nx;
						st_q <= ST_WAIT;
					end
				end
				ST_NB_D2: begin
					dist2_q <= dist2_q + mul_p;
					if (k_q == 2'd2) begin
						st_q <= ST_NB_CHK;
					end else begin
						k_q  <= k_nx;
						st_q <= ST_WAIT;
					end
				end
				ST_NB_CHK: begin
					if (dist_ok) begin
						ret_q <= ST_NB_R;
						st_q  <= ST_WAIT;
					end else begin
						st_q <= ST_FIN;
					end
				end
				ST_NB_R: begin
					ret_q <= ST_NB_E1;
					st_q  <= ST_WAIT;
				end
				ST_NB_E1: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_NB_E2;
					st_q   <= ST_WAIT;
				end
				ST_NB_E2: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_NB_E3;
					st_q   <= ST_WAIT;
				end
				ST_NB_E3: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_NB_E4;
					st_q   <= ST_WAIT;
				end
				ST_NB_E4: begin
					clip_q <= clip_q | rs_f[64];
					ret_q  <= ST_NB_E5;
					st_q   <= ST_WAIT;
				end
				ST_NB_E5: begin
					clip_q <= clip_q | rs_f[64];
					k_q    <= 2'd0;
					ret_q  <= ST_NB_C;
					st_q   <= ST_WAIT;
				end
				ST_NB_C: begin
					clip_q <= clip_q | qs[64];
					ret_q  <= ST_NB_FM;
					st_q   <= ST_WAIT;
				end
				ST_NB_FM: begin
					ret_q <= ST_NB_FA;
					st_q  <= ST_WAIT;
				end
				ST_NB_FA: begin
					field_q[k_q] <= acc_fd[ACC_WIDTH-1:0];
					clip_q       <= clip_q | qs[64] | acc_fd[ACC_WIDTH];
					ret_q        <= ST_NB_GM;
					st_q         <= ST_WAIT;
				end
				ST_NB_GM: begin
					ret_q <= ST_NB_GA;
					st_q  <= ST_WAIT;
				end
				ST_NB_GA: begin
					force_q[k_q] <= acc_fc[ACC_WIDTH-1:0];
					clip_q       <= clip_q | qs[64] | acc_fc[ACC_WIDTH];
					if (k_q == 2'd2) begin
						st_q <= ST_FIN;
					end else begin
						k_q   <= k_nx;
						ret_q <= ST_NB_C;
						st_q  <= ST_WAIT;
					end
				end
				ST_FIN: begin
					if (!it_q.last) begin
						st_q <= ST_IDLE;
					end else if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							out_q[i]     <= OUT_W'(64'($signed(force_q[i])));
							out_q[3 + i] <= OUT_W'(64'($signed(field_q[i])));
							force_q[i]   <= '0;
							field_q[i]   <= '0;
						end
						sat_q  <= clip_q;
						clip_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign force_x   = out_q[0];
	assign force_y   = out_q[1];
	assign force_z   = out_q[2];
	assign field_x   = out_q[3];
	assign field_y   = out_q[4];
	assign field_z   = out_q[5];
	assign saturated = sat_q;

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		any_done |-> st_q == ST_WAIT)
		else $error("unit finished while sequencer not waiting");
	a_hdr_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DISP && it_q.op == OP_HDR) |=>
		(!clip_q && force_q[0] == '0 && field_q[2] == '0))
		else $error("header did not clear sums");
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (!clip_q && force_q[1] == '0 && field_q[0] == '0))
		else $error("sums not cleared on emit");
	a_emit_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> it_q.last)
		else $error("result emitted for a word without last");

endmodule

`default_nettype wire

/* rtl/core/coulomb_dielectric_pair_force_core.sv */
// Cutoff Coulomb force and field on one atom with a dielectric weight. Words
// stream per atom (header, optional self term, neighbors); the one marked last
// returns the saturating Q32.16 sums. A two-entry queue takes words while the
// back end works on one word at a time through a shared 64-bit multiplier
// (four 32x32 steps), a one-bit-per-cycle 128/64 divider and a two-bit-per-
// cycle square root. The time of a neighbor inside the cutoff is set mostly
// by its nine divider passes.
// Depends on cfd_pkg, cfd_front and cfd_back.
`default_nettype none

module coulomb_dielectric_pair_force_core import cfd_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ACC_WIDTH = ACC_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            kind,
	input  wire logic [31:0]           vec_x,
	input  wire logic [31:0]           vec_y,
	input  wire logic [31:0]           vec_z,
	input  wire logic [31:0]           charge,
	input  wire logic [31:0]           permittivity,
	input  wire logic [1:0]            special_class,
	input  wire logic [31:0]           curvature,
	input  wire logic [31:0]           area,
	input  wire logic [31:0]           pair_cutoff_sq,
	input  wire logic [31:0]           pair_scale,
	input  wire logic                  last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [OUT_W-1:0]           force_x,
	output logic [OUT_W-1:0]           force_y,
	output logic [OUT_W-1:0]           force_z,
	output logic [OUT_W-1:0]           field_x,
	output logic [OUT_W-1:0]           field_y,
	output logic [OUT_W-1:0]           field_z,
	output logic                       saturated
);

	logic  pop;
	logic  head_valid;
	item_t head;

	// Accept and classify words
	cfd_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.charge(charge), .permittivity(permittivity), .special_class(special_class),
		.curvature(curvature), .area(area), .pair_cutoff_sq(pair_cutoff_sq),
		.pair_scale(pair_scale), .last(last),
		.pop(pop), .head_valid(head_valid), .head(head)
	);

	// Evaluate and accumulate
	cfd_back #(
		.FRAC_BITS(FRAC_BITS),
		.ACC_WIDTH(ACC_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(pop),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.out_valid(out_valid), .out_ready(out_ready),
		.force_x(force_x), .force_y(force_y), .force_z(force_z),
		.field_x(field_x), .field_y(field_y), .field_z(field_z),
		.saturated(saturated)
	);

endmodule

`default_nettype wire
